[sv/at_lfb_pkg.sv]
// Shared constants, types and payload layout for the AT line framer.
package at_lfb_pkg;

    localparam int NUM_BUFFERS  = 4;
    localparam int BUFFER_BYTES = 256;

    localparam int BUF_IW   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int BUF_AW   = $clog2(BUFFER_BYTES);
    localparam int STORE_D  = NUM_BUFFERS * BUFFER_BYTES;
    localparam int STORE_AW = $clog2(STORE_D);

    localparam int BYTE_W   = 8;
    localparam int REQ_W    = 2;
    localparam int BIDX_W   = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;
    localparam int S_USER_W = REQ_W;
    localparam int M_USER_W = 1;

    localparam logic [REQ_W-1:0] REQ_BYTE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ARM     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd3;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic              accepted;
        logic              echo_valid;
        logic [BYTE_W-1:0] echo_byte;
        logic              msg_valid;
        logic [BIDX_W-1:0] msg_buffer;
        logic [BYTE_W-1:0] msg_length;
        logic              msg_is_data;
        logic              rd_ok;
    } res_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } mem_req_t;

endpackage

[sv/at_line_framer_buffer_pool.sv]
// Top level: stream ports, result stage, output register and frame store.
//
//  channel      | direction | fields (lowest bit first)
//  s_axis       | in        | tuser: req_type; tdata: byte_value, buffer_index,
//               |           |   byte_address, data_length
//  m_axis       | out       | tuser: msg_is_data; tdata: accepted, echo_valid,
//               |           |   echo_byte, msg_valid, msg_buffer, msg_length, read_data
//  cfg          | in        | cfg_wdata: echo_enable, written when cfg_we is high
//
// One word per cycle unless m_axis stalls; a result goes through the result stage
// (with the registered read of the frame store) and then the output register.
// Reset clears all framing state and frees every buffer; echo_enable resets to 1.
// Frame store contents are not cleared by reset.
// A stalled output holds the result stage, and input is refused only when both are full.
module at_line_framer_buffer_pool (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // byte_value[7:0], buffer_index[9:8], byte_address[17:10], data_length[25:18]
    input  logic [at_lfb_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [at_lfb_pkg::S_USER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // accepted[0], echo_valid[1], echo_byte[9:2], msg_valid[10], msg_buffer[12:11],
    // msg_length[20:13], read_data[28:21]
    output logic [at_lfb_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // msg_is_data[0]
    output logic [at_lfb_pkg::M_USER_W-1:0]  m_axis_tuser
);
    import at_lfb_pkg::*;

    logic        accept;
    logic        out_load;
    res_t        res;
    mem_req_t    mem;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] read_data;

    logic        s1_valid_reg, s1_valid_next;
    res_t        s1_res_reg;
    logic        out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_USER_W-1:0] out_user_reg;

    assign out_load      = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || out_load;
    assign accept        = s_axis_tvalid && s_axis_tready;

    at_lfb_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .req_type     (s_axis_tuser[REQ_W-1:0]),
        .byte_value   (s_axis_tdata[7:0]),
        .buffer_index (s_axis_tdata[9:8]),
        .byte_address (s_axis_tdata[17:10]),
        .data_length  (s_axis_tdata[25:18]),
        .res          (res),
        .mem          (mem)
    );

    at_lfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_D)
    ) u_store (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (ram_rdata)
    );

    assign read_data = s1_res_reg.rd_ok ? ram_rdata : '0;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (out_load)
        begin
            out_data_reg <= {3'b000,
                             read_data,
                             s1_res_reg.msg_length,
                             s1_res_reg.msg_buffer,
                             s1_res_reg.msg_valid,
                             s1_res_reg.echo_byte,
                             s1_res_reg.echo_valid,
                             s1_res_reg.accepted};
            out_user_reg <= s1_res_reg.msg_is_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

[sv/at_lfb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module at_lfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/at_lfb_core.sv]
// Framer state: buffer allocation, CR LF line framing, data-mode counting.
module at_lfb_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            accept,
    input  logic [at_lfb_pkg::REQ_W-1:0]    req_type,
    input  logic [at_lfb_pkg::BYTE_W-1:0]   byte_value,
    input  logic [at_lfb_pkg::BIDX_W-1:0]   buffer_index,
    input  logic [at_lfb_pkg::BYTE_W-1:0]   byte_address,
    input  logic [at_lfb_pkg::BYTE_W-1:0]   data_length,
    output at_lfb_pkg::res_t                res,
    output at_lfb_pkg::mem_req_t            mem
);
    import at_lfb_pkg::*;

    logic                   echo_enable_reg;
    logic [NUM_BUFFERS-1:0] busy_mask_reg,     busy_mask_next;
    logic                   current_held_reg,  current_held_next;
    logic [BUF_IW-1:0]      current_index_reg, current_index_next;
    logic [BUF_AW-1:0]      line_count_reg,    line_count_next;
    logic                   last_was_cr_reg,   last_was_cr_next;
    logic [BYTE_W-1:0]      data_expected_reg, data_expected_next;
    logic [BYTE_W-1:0]      data_count_reg,    data_count_next;

    logic                   free_found;
    logic [BUF_IW-1:0]      free_index;
    logic [BYTE_W-1:0]      dc_inc;
    logic                   crlf;

    always_comb
    begin
        free_found = 1'b0;
        free_index = '0;
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            if (!free_found && !busy_mask_reg[i])
            begin
                free_found = 1'b1;
                free_index = BUF_IW'(i);
            end
        end
    end

    assign dc_inc = data_count_reg + 1'b1;
    assign crlf   = (byte_value == CH_LF) && last_was_cr_reg && (line_count_reg != '0);

    always_comb
    begin
        busy_mask_next     = busy_mask_reg;
        current_held_next  = current_held_reg;
        current_index_next = current_index_reg;
        line_count_next    = line_count_reg;
        last_was_cr_next   = last_was_cr_reg;
        data_expected_next = data_expected_reg;
        data_count_next    = data_count_reg;
        res                = '0;
        mem                = '0;
        mem.wdata          = byte_value;
        mem.raddr          = {BUF_IW'(buffer_index), BUF_AW'(byte_address)};

        if (accept)
        begin
            case (req_type)
                REQ_BYTE:
                begin
                    if (current_held_reg || free_found)
                    begin
                        if (!current_held_reg)
                        begin
                            busy_mask_next[free_index] = 1'b1;
                            current_index_next         = free_index;
                            current_held_next          = 1'b1;
                        end
                        res.accepted = 1'b1;
                        if (data_expected_reg == '0)
                        begin
                            res.echo_valid = echo_enable_reg;
                            res.echo_byte  = echo_enable_reg ? byte_value : '0;
                            if (32'(line_count_reg) < BUFFER_BYTES - 1)
                            begin
                                mem.we           = 1'b1;
                                mem.waddr        = {current_index_next, line_count_reg};
                                line_count_next  = line_count_reg + 1'b1;
                                last_was_cr_next = (byte_value == CH_CR);
                                if (crlf)
                                begin
                                    line_count_next  = line_count_reg - 1'b1;
                                    last_was_cr_next = 1'b0;
                                    if (line_count_reg > BUF_AW'(1))
                                    begin
                                        res.msg_valid     = 1'b1;
                                        res.msg_buffer    = BIDX_W'(current_index_next);
                                        res.msg_length    = BYTE_W'(line_count_reg - 1'b1);
                                        current_held_next = 1'b0;
                                        line_count_next   = '0;
                                    end
                                end
                            end
                            else
                            begin
                                line_count_next  = '0;
                                last_was_cr_next = 1'b0;
                            end
                        end
                        else
                        begin
                            mem.we          = 1'b1;
                            mem.waddr       = {current_index_next, BUF_AW'(data_count_reg)};
                            data_count_next = dc_inc;
                            if (dc_inc == data_expected_reg)
                            begin
                                res.msg_valid      = 1'b1;
                                res.msg_buffer     = BIDX_W'(current_index_next);
                                res.msg_length     = dc_inc;
                                res.msg_is_data    = 1'b1;
                                data_expected_next = '0;
                                current_held_next  = 1'b0;
                            end
                        end
                    end
                end
                REQ_RELEASE:
                begin
                    for (int i = 0; i < NUM_BUFFERS; i++)
                    begin
                        if (32'(buffer_index) == i)
                        begin
                            busy_mask_next[i] = 1'b0;
                        end
                    end
                end
                REQ_ARM:
                begin
                    data_expected_next = data_length;
                    data_count_next    = '0;
                end
                default:
                begin
                    mem.re    = 1'b1;
                    res.rd_ok = (32'(buffer_index) < NUM_BUFFERS)
                             && (32'(byte_address) < BUFFER_BYTES);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg   <= 1'b1;
            busy_mask_reg     <= '0;
            current_held_reg  <= 1'b0;
            current_index_reg <= '0;
            line_count_reg    <= '0;
            last_was_cr_reg   <= 1'b0;
            data_expected_reg <= '0;
            data_count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                echo_enable_reg <= cfg_wdata;
            end
            busy_mask_reg     <= busy_mask_next;
            current_held_reg  <= current_held_next;
            current_index_reg <= current_index_next;
            line_count_reg    <= line_count_next;
            last_was_cr_reg   <= last_was_cr_next;
            data_expected_reg <= data_expected_next;
            data_count_reg    <= data_count_next;
        end
    end

endmodule
